// ===== hdl/pfr_pkg.sv =====
// Shared types and constants for the polygon fit residual block.
`timescale 1ns / 1ps

package pfr_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int CFG_W     = 31;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_SHAPE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FORM   = 2'd2;

	localparam logic [30:0] RADIUS_RST = 31'd65536;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic [15:0]        pose_angle;
	} pfr_in_t;

	typedef struct packed {
		logic [47:0] residual;
		logic        inside_res;
	} pfr_out_t;

	// first-octant sine/cosine after the octant swap, plus quadrant
	typedef struct packed {
		logic [1:0]  q;
		logic [30:0] s0;
		logic [30:0] c0;
	} pfr_sc_t;

	localparam logic [47:0] RES_MAX = 48'hFFFF_FFFF_FFFF;

	localparam logic [31:0] PI4_Q32 = 32'd3373259426;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic [29:0] APO_TRI = 30'd536870912;
	localparam logic [29:0] APO_SQR = 30'd759250125;

	// edge normal phases, [shape][edge]; square edge 3 comes from edge 0
	localparam logic [31:0] EDGE_PHASE [2][3] = '{
		'{32'd715827883, 32'd2147483648, 32'd3579139413},
		'{32'd536870912, 32'd1610612736, 32'd2684354560}
	};

	// reciprocal multipliers: floor(v/d) = (v*m) >> sh for v < 2^31
	localparam int DIV_SH_SIN [4] = '{38, 37, 36, 34};
	localparam int DIV_SH_COS [4] = '{38, 37, 36, 35};

	localparam logic [31:0] DIV_M_SIN [4] = '{
		32'(((64'd1 << 38) / 64'd72) + 64'd1),
		32'(((64'd1 << 37) / 64'd42) + 64'd1),
		32'(((64'd1 << 36) / 64'd20) + 64'd1),
		32'(((64'd1 << 34) / 64'd6) + 64'd1)
	};

	localparam logic [31:0] DIV_M_COS [4] = '{
		32'(((64'd1 << 38) / 64'd90) + 64'd1),
		32'(((64'd1 << 37) / 64'd56) + 64'd1),
		32'(((64'd1 << 36) / 64'd30) + 64'd1),
		32'(((64'd1 << 35) / 64'd12) + 64'd1)
	};

endpackage

// ===== hdl/pfr_sincos.sv =====
// Pipelined sine/cosine of a phase by octant folding and a Horner series.
`timescale 1ns / 1ps

module pfr_sincos import pfr_pkg::*; (
	input  logic        clk,
	input  logic        en,
	input  logic [15:0] angle,
	input  logic [31:0] offset,
	output pfr_sc_t     sc
);

	logic [31:0] ph_s1;
	logic [29:0] u_s2;
	logic [61:0] xp_s3;
	logic [59:0] x2p_s4;
	logic [1:0]  q_l  [2:12];
	logic        sw_l [2:12];
	logic [29:0] x_l  [4:11];
	logic [29:0] x2_l [5:11];
	logic [62:0] dsn [4];
	logic [62:0] dcs [4];
	logic [60:0] psn [1:3];
	logic [60:0] pcs [1:3];
	logic [30:0] tsn [4];
	logic [30:0] tcs [4];
	logic [60:0] fsn_s12;
	logic [60:0] fcs_s12;
	logic [30:0] sn;
	logic [30:0] cs;

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			tsn[j] = ONE_Q30 - 31'(dsn[j] >> DIV_SH_SIN[j]);
			tcs[j] = ONE_Q30 - 31'(dcs[j] >> DIV_SH_COS[j]);
		end
		sn = fsn_s12[60:30];
		cs = ONE_Q30 - 31'(fcs_s12[60:31]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ph_s1 <= {angle, 16'h0000} + offset;

			q_l[2]  <= ph_s1[31:30];
			sw_l[2] <= ph_s1[29];
			u_s2    <= ph_s1[29] ? 30'(ONE_Q30 - {1'b0, ph_s1[29:0]}) : ph_s1[29:0];
			for (int i = 3; i <= 12; i++) begin
				q_l[i]  <= q_l[i-1];
				sw_l[i] <= sw_l[i-1];
			end

			xp_s3  <= 62'(u_s2) * 62'(PI4_Q32);
			x_l[4] <= xp_s3[60:31];
			x2p_s4 <= 60'(xp_s3[60:31]) * 60'(xp_s3[60:31]);
			for (int i = 5; i <= 11; i++)
				x_l[i] <= x_l[i-1];
			x2_l[5] <= x2p_s4[59:30];
			for (int i = 6; i <= 11; i++)
				x2_l[i] <= x2_l[i-1];

			dsn[0] <= 63'(x2p_s4[59:30]) * 63'(DIV_M_SIN[0]);
			dcs[0] <= 63'(x2p_s4[59:30]) * 63'(DIV_M_COS[0]);
			for (int j = 1; j < 4; j++) begin
				psn[j] <= 61'(x2_l[3+2*j]) * 61'(tsn[j-1]);
				pcs[j] <= 61'(x2_l[3+2*j]) * 61'(tcs[j-1]);
				dsn[j] <= 63'(psn[j][60:30]) * 63'(DIV_M_SIN[j]);
				dcs[j] <= 63'(pcs[j][60:30]) * 63'(DIV_M_COS[j]);
			end

			fsn_s12 <= 61'(x_l[11]) * 61'(tsn[3]);
			fcs_s12 <= 61'(x2_l[11]) * 61'(tcs[3]);

			sc.q  <= q_l[12];
			sc.s0 <= sw_l[12] ? cs : sn;
			sc.c0 <= sw_l[12] ? sn : cs;
		end
	end

endmodule

// ===== hdl/polygon_fit_residual_top.sv =====
// Residual of a sample point against a regular triangle or square, top level.
`timescale 1ns / 1ps

// Takes one point and pose per cycle unless the output stalls, and returns one residual
// per item. The pipeline depth is set by the sine/cosine series: each Horner
// step is a multiply followed by a reciprocal multiply, each in its own stage.
// Stalls on the output freeze the whole pipeline; no item is lost or repeated.
// Configuration must be written while no items are in flight.

module polygon_fit_residual_top import pfr_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  pfr_in_t              in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output pfr_out_t             out_item
);

	localparam int NS = 23;
	localparam logic [64:0] RND_IN  = 65'(1) << (FRAC_BITS - 1);
	localparam logic [64:0] RND_OUT = 65'(1) << (FRAC_BITS - 2);
	localparam logic signed [64:0] RND_NEG = 65'sd8191;
	localparam logic signed [64:0] RND_POS = 65'sd8192;

	logic        shape_select_q;
	logic [30:0] circumradius_q;
	logic        residual_form_q;

	logic        adv;
	logic        v_s [1:NS];

	logic signed [32:0] dx_l [1:14];
	logic signed [32:0] dy_l [1:14];
	logic [30:0]        r_s1;
	logic [60:0]        apo_p_s2;
	logic [46:0]        apo_l [3:16];
	logic               sq_l [1:17];
	logic               fm_l [1:22];

	pfr_sc_t            sc [3];
	logic signed [31:0] sv_c [4];
	logic signed [31:0] cv_c [4];
	logic signed [31:0] sv_s14 [4];
	logic signed [31:0] cv_s14 [4];
	logic signed [64:0] mx_s15 [4];
	logic signed [64:0] my_s15 [4];
	logic signed [50:0] tx_s16 [4];
	logic signed [50:0] ty_s16 [4];
	logic signed [52:0] h_s17 [4];
	logic [51:0]        mag_s18 [4];
	logic               in_l [18:22];
	logic [51:0]        m01_s19;
	logic [51:0]        m23_s19;
	logic [51:0]        dmin_s20;
	logic [36:0]        dist_s21;
	logic [63:0]        p_s22;
	logic               big_s22;
	logic [36:0]        d0_s22;
	logic               inside_c;
	logic [64:0]        rq_c;
	logic [47:0]        res_c;

	assign adv       = !v_s[NS] || out_ready;
	assign in_ready  = adv;
	assign out_valid = v_s[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_select_q  <= 1'b0;
			circumradius_q  <= RADIUS_RST;
			residual_form_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHAPE:  shape_select_q  <= cfg_data[0];
				CFG_RADIUS: circumradius_q  <= cfg_data[30:0];
				CFG_FORM:   residual_form_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= NS; i++)
				v_s[i] <= 1'b0;
		end else if (adv) begin
			v_s[1] <= in_valid;
			for (int i = 2; i <= NS; i++)
				v_s[i] <= v_s[i-1];
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_sc
		pfr_sincos u_sincos (
			.clk    (clk),
			.en     (adv),
			.angle  (in_item.pose_angle),
			.offset (EDGE_PHASE[shape_select_q][k]),
			.sc     (sc[k])
		);
	end

	always_comb begin
		logic [1:0]  qk;
		logic signed [31:0] s0;
		logic signed [31:0] c0;
		qk = 2'd0;
		s0 = '0;
		c0 = '0;
		for (int k = 0; k < 4; k++) begin
			if (k < 3) begin
				qk = sc[k].q;
				s0 = $signed({1'b0, sc[k].s0});
				c0 = $signed({1'b0, sc[k].c0});
			end else begin
				qk = sc[0].q + 2'd3;
				s0 = $signed({1'b0, sc[0].s0});
				c0 = $signed({1'b0, sc[0].c0});
			end
			case (qk)
				2'd0: begin sv_c[k] = s0;  cv_c[k] = c0;  end
				2'd1: begin sv_c[k] = c0;  cv_c[k] = -s0; end
				2'd2: begin sv_c[k] = -s0; cv_c[k] = -c0; end
				default: begin sv_c[k] = -c0; cv_c[k] = s0; end
			endcase
		end
	end

	always_comb begin
		inside_c = 1'b1;
		for (int k = 1; k < 4; k++) begin
			if (k < 3 || sq_l[17]) begin
				if ((!h_s17[0][52] && h_s17[0] != 0 && h_s17[k][52]) ||
				    (h_s17[0][52] && !h_s17[k][52] && h_s17[k] != 0))
					inside_c = 1'b0;
			end
		end
	end

	always_comb begin
		if (in_l[22])
			rq_c = (65'(p_s22) + RND_IN) >> FRAC_BITS;
		else
			rq_c = (65'(p_s22) + RND_OUT) >> (FRAC_BITS - 1);
		if (!fm_l[22])
			res_c = in_l[22] ? '0 : 48'(d0_s22);
		else if (big_s22 || rq_c > 65'(RES_MAX))
			res_c = RES_MAX;
		else
			res_c = 48'(rq_c);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx_l[1] <= 33'(in_item.point_x) - 33'(in_item.pose_x);
			dy_l[1] <= 33'(in_item.point_y) - 33'(in_item.pose_y);
			r_s1    <= circumradius_q;
			sq_l[1] <= shape_select_q;
			fm_l[1] <= residual_form_q;
			for (int i = 2; i <= 14; i++) begin
				dx_l[i] <= dx_l[i-1];
				dy_l[i] <= dy_l[i-1];
			end
			for (int i = 2; i <= 17; i++)
				sq_l[i] <= sq_l[i-1];
			for (int i = 2; i <= 22; i++)
				fm_l[i] <= fm_l[i-1];

			apo_p_s2 <= 61'(r_s1) * 61'(sq_l[1] ? APO_SQR : APO_TRI);
			apo_l[3] <= 47'((apo_p_s2 + 61'(8192)) >> 14);
			for (int i = 4; i <= 16; i++)
				apo_l[i] <= apo_l[i-1];

			for (int k = 0; k < 4; k++) begin
				sv_s14[k] <= sv_c[k];
				cv_s14[k] <= cv_c[k];
				mx_s15[k] <= 65'(dx_l[14]) * 65'(cv_s14[k]);
				my_s15[k] <= 65'(dy_l[14]) * 65'(sv_s14[k]);
				tx_s16[k] <= 51'((mx_s15[k] + (mx_s15[k][64] ? RND_NEG : RND_POS)) >>> 14);
				ty_s16[k] <= 51'((my_s15[k] + (my_s15[k][64] ? RND_NEG : RND_POS)) >>> 14);
				h_s17[k]  <= $signed({6'b0, apo_l[16]}) - 53'(tx_s16[k]) - 53'(ty_s16[k]);
				if (k == 3 && !sq_l[17])
					mag_s18[k] <= '1;
				else
					mag_s18[k] <= h_s17[k][52] ? 52'(-h_s17[k]) : 52'(h_s17[k]);
			end

			in_l[18] <= inside_c;
			for (int i = 19; i <= 22; i++)
				in_l[i] <= in_l[i-1];

			m01_s19  <= (mag_s18[0] < mag_s18[1]) ? mag_s18[0] : mag_s18[1];
			m23_s19  <= (mag_s18[2] < mag_s18[3]) ? mag_s18[2] : mag_s18[3];
			dmin_s20 <= (m01_s19 < m23_s19) ? m01_s19 : m23_s19;
			dist_s21 <= 37'(({1'b0, dmin_s20} + 53'(32768)) >> 16);
			p_s22    <= 64'(dist_s21[31:0]) * 64'(dist_s21[31:0]);
			big_s22  <= |dist_s21[36:32];
			d0_s22   <= dist_s21;

			out_item.residual   <= res_c;
			out_item.inside_res <= in_l[22];
		end
	end

endmodule
